// ----- src/fixed_timestep_accumulator_macros.svh -----
// Assertion helpers shared by the accumulator modules.
// Each macro expects clk_i and rst_ni to be visible in the calling module.
`ifndef FIXED_TIMESTEP_ACCUMULATOR_MACROS_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define FTA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fta_pkg.sv -----
`timescale 1ns / 1ps

package fta_pkg;

  // Accumulator sizing.
  localparam int TIME_BITS = 32;
  localparam int ACC_W     = TIME_BITS + 1;
  // Wide scratch width for sums and compares of the accumulator.
  localparam int WIDE_W    = 65;

  // Field widths.
  localparam int ELAPSED_W = 32;
  localparam int PERIOD_W  = 32;
  localparam int STEPS_W   = 8;
  localparam int ALPHA_W   = 16;
  localparam int REM_W     = PERIOD_W + 1;
  localparam int FCNT_W    = $clog2(ALPHA_W);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD = 2'd0,
    REG_MAX_STEPS   = 2'd1
  } cfg_reg_e;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 32'd16667;
  localparam logic [STEPS_W-1:0]  MAX_STEPS_RST   = 8'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sub;
    logic drop;
    logic frac_init;
    logic frac_step;
    logic out_load;
  } fta_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_ge_period;
    logic steps_at_max;
    logic frac_last;
  } fta_status_t;

endpackage

// ----- src/fta_datapath.sv -----
`timescale 1ns / 1ps
`include "fixed_timestep_accumulator_macros.svh"

module fta_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [fta_pkg::ELAPSED_W-1:0]  elapsed_i,
  input  fta_pkg::fta_cmd_t              cmd_i,
  output fta_pkg::fta_status_t           status_o,
  output logic [fta_pkg::STEPS_W-1:0]    steps_o,
  output logic [fta_pkg::ALPHA_W-1:0]    alpha_o,
  output logic                           lag_dropped_o
);
  import fta_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic [STEPS_W-1:0]  max_steps_q;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [STEPS_W-1:0]  cnt_q, cnt_d;
  logic                dropped_q, dropped_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [ALPHA_W-1:0]  quot_q, quot_d;
  logic [FCNT_W-1:0]   fcnt_q, fcnt_d;
  logic [STEPS_W-1:0]  steps_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic                lag_q;

  logic [WIDE_W-1:0]   acc_wide;
  logic [WIDE_W-1:0]   period_wide;
  logic [WIDE_W-1:0]   sum_wide;
  logic [WIDE_W-1:0]   diff_wide;
  logic                elapsed_pos;
  logic [REM_W-1:0]    rem_sh;
  logic                rem_ge;
  logic                period_zero;

  // Widened operands for the accumulator arithmetic.
  assign acc_wide    = WIDE_W'(acc_q);
  assign period_wide = WIDE_W'(period_q);
  assign elapsed_pos = !elapsed_i[ELAPSED_W-1] && (elapsed_i != '0);
  assign sum_wide    = acc_wide + WIDE_W'(elapsed_i);
  assign diff_wide   = acc_wide - period_wide;
  assign period_zero = (period_q == '0);

  // One restoring division step for the fraction.
  assign rem_sh = {rem_q[REM_W-2:0], 1'b0};
  assign rem_ge = (rem_sh >= REM_W'(period_q));

  // Status back to the controller.
  assign status_o.acc_ge_period = (acc_wide >= period_wide);
  assign status_o.steps_at_max  = (cnt_q == max_steps_q);
  assign status_o.frac_last     = (fcnt_q == FCNT_W'(ALPHA_W - 1));

  // Next-state logic of the working registers.
  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    dropped_d = dropped_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    fcnt_d    = fcnt_q;
    if (cmd_i.load) begin
      if (elapsed_pos) begin
        acc_d = sum_wide[ACC_W-1:0];
      end
      cnt_d     = '0;
      dropped_d = 1'b0;
    end
    if (cmd_i.sub) begin
      acc_d = diff_wide[ACC_W-1:0];
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.drop) begin
      acc_d     = '0;
      dropped_d = 1'b1;
    end
    if (cmd_i.frac_init) begin
      rem_d  = acc_wide[REM_W-1:0];
      quot_d = '0;
      fcnt_d = '0;
    end
    if (cmd_i.frac_step) begin
      rem_d  = rem_ge ? (rem_sh - REM_W'(period_q)) : rem_sh;
      quot_d = {quot_q[ALPHA_W-2:0], rem_ge};
      fcnt_d = fcnt_q + 1'b1;
    end
  end

  // Configuration registers and the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= STEP_PERIOD_RST;
      max_steps_q <= MAX_STEPS_RST;
      acc_q       <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == REG_STEP_PERIOD)) begin
        period_q <= cfg_data_i[PERIOD_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == REG_MAX_STEPS)) begin
        max_steps_q <= cfg_data_i[STEPS_W-1:0];
      end
      acc_q <= acc_d;
    end
  end

  // Working registers and the result holding registers.
  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    dropped_q <= dropped_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    fcnt_q    <= fcnt_d;
    if (cmd_i.out_load) begin
      steps_q <= cnt_q;
      alpha_q <= period_zero ? '0 : quot_q;
      lag_q   <= dropped_q;
    end
  end

  assign steps_o       = steps_q;
  assign alpha_o       = alpha_q;
  assign lag_dropped_o = lag_q;

  `FTA_ASSERT_NEXT(a_drop_clears, cmd_i.drop, acc_q == '0, "drop did not clear accumulator")
  `FTA_ASSERT_SAME(a_rem_below, cmd_i.frac_step && !period_zero, rem_q < REM_W'(period_q), "fraction remainder not below period")
  `FTA_ASSERT_SAME(a_sub_fits, cmd_i.sub, status_o.acc_ge_period && !status_o.steps_at_max, "subtract issued without room")

endmodule

// ----- src/fta_ctrl.sv -----
`timescale 1ns / 1ps
`include "fixed_timestep_accumulator_macros.svh"

module fta_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  fta_pkg::fta_status_t status_i,
  output fta_pkg::fta_cmd_t    cmd_o
);
  import fta_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_FRAC_INIT,
    ST_FRAC,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;

  // Commands and next state.
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status_i.acc_ge_period && !status_i.steps_at_max) begin
          cmd_o.sub = 1'b1;
        end else begin
          cmd_o.drop = status_i.acc_ge_period;
          state_d    = ST_FRAC_INIT;
        end
      end
      ST_FRAC_INIT: begin
        cmd_o.frac_init = 1'b1;
        state_d         = ST_FRAC;
      end
      ST_FRAC: begin
        cmd_o.frac_step = 1'b1;
        if (status_i.frac_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the result once the holding register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FTA_ASSERT_SAME(a_no_load_idle, in_ready_o, !cmd_o.out_load, "result loaded while idle")
  `FTA_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_ready_o, "ready held after transfer")
  `FTA_ASSERT_SAME(a_valid_from_load, $rose(out_valid_q), $past(cmd_o.out_load), "output valid without load")

endmodule

// ----- src/fixed_timestep_accumulator.sv -----
`timescale 1ns / 1ps
// Channel | Handshake                | Payload
// --------+--------------------------+----------------------------------
// in      | in_valid_i / in_ready_o  | elapsed_i
// out     | out_valid_o / out_ready_i| steps_o, alpha_o, lag_dropped_o
// cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item at a time: after accept, one subtract of the period per step taken
// (at most max_steps), then setup and the 16 quotient bits of the
// shift-subtract fraction divider, and finally the result load.
// Reset clears the accumulator and loads step_period 16667, max_steps 5.
// A waiting result does not block the next transfer in; it only holds the
// next finished item in the done state, in_ready_o low, until the output register frees up.

module fixed_timestep_accumulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fta_pkg::ELAPSED_W-1:0]  elapsed_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fta_pkg::STEPS_W-1:0]    steps_o,
  output logic [fta_pkg::ALPHA_W-1:0]    alpha_o,
  output logic                           lag_dropped_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fta_pkg::*;

  fta_cmd_t    cmd;
  fta_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  fta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fta_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .elapsed_i     (elapsed_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .steps_o       (steps_o),
    .alpha_o       (alpha_o),
    .lag_dropped_o (lag_dropped_o)
  );

endmodule
